FILE: hdl/nand_address_cycle_generator_unit_macros.svh
// Assertion macros used by the address cycle generator serialiser.
`ifndef NAND_ADDRESS_CYCLE_GENERATOR_UNIT_MACROS_SVH
`define NAND_ADDRESS_CYCLE_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// Condition must hold in the same cycle as the trigger.
`define NACG_ASSERT_IMP(label, clock, reset, pre, post) \
  label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
    else $error("address cycle generator check failed");
// Condition must hold in the cycle after the trigger.
`define NACG_ASSERT_NXT(label, clock, reset, pre, post) \
  label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
    else $error("address cycle generator check failed");
`else
`define NACG_ASSERT_IMP(label, clock, reset, pre, post)
`define NACG_ASSERT_NXT(label, clock, reset, pre, post)
`endif

`endif

FILE: hdl/nacg_pkg.sv
package nacg_pkg;

  // Field widths of one request.
  localparam int UnitW   = 3;
  localparam int PlaneW  = 3;
  localparam int BlockW  = 16;
  localparam int PageW   = 10;
  localparam int OffsetW = 16;

  // Register widths.
  localparam int CycW      = 3;
  localparam int PpbW      = 11;
  localparam int CountW    = 17;
  localparam int SizeW     = 17;
  localparam int PlaneCntW = 4;
  localparam int UnitCntW  = 4;
  localparam int CfgDataW  = 17;
  localparam int CfgIndexW = 3;

  // Row value is block * block_pages + page, which fits in 27 bits.
  localparam int RowW   = BlockW + PpbW;
  // Wide enough for the sum of column and row cycle counts.
  localparam int TotalW = 4;
  localparam int ByteW  = 8;

  localparam int MaxAddressCycles = 8;
  localparam logic [CycW-1:0] CycleLimit = 3'd4;

  // Register indexes on the write port.
  typedef enum logic [CfgIndexW-1:0] {
    CfgColumnCycles    = 3'd0,
    CfgRowCycles       = 3'd1,
    CfgBlockPages      = 3'd2,
    CfgBlockCount      = 3'd3,
    CfgPageTotalSize   = 3'd4,
    CfgPlaneCount      = 3'd5,
    CfgLogicalUnitCnt  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [CycW-1:0]      column_cycles;
    logic [CycW-1:0]      row_cycles;
    logic [PpbW-1:0]      block_pages;
    logic [CountW-1:0]    block_count;
    logic [SizeW-1:0]     page_total_size;
    logic [PlaneCntW-1:0] plane_count;
    logic [UnitCntW-1:0]  logical_unit_count;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic [UnitW-1:0]   logical_unit;
    logic [PlaneW-1:0]  plane_index;
    logic [BlockW-1:0]  block_index;
    logic [PageW-1:0]   page_index;
    logic [OffsetW-1:0] column_offset;
  } req_t;

  // One checked request, ready to be sent out byte by byte.
  typedef struct packed {
    logic               err;
    logic [CycW-1:0]    ncol;
    logic [TotalW-1:0]  total;
    logic [OffsetW-1:0] col;
    logic [RowW-1:0]    row;
  } job_t;

endpackage

FILE: hdl/nacg_req_if.sv
interface nacg_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [nacg_pkg::UnitW-1:0]    logical_unit;
  logic [nacg_pkg::PlaneW-1:0]   plane_index;
  logic [nacg_pkg::BlockW-1:0]   block_index;
  logic [nacg_pkg::PageW-1:0]    page_index;
  logic [nacg_pkg::OffsetW-1:0]  column_offset;

  modport source (
    output valid, mode, logical_unit, plane_index, block_index, page_index, column_offset,
    input  ready
  );
  modport sink (
    input  valid, mode, logical_unit, plane_index, block_index, page_index, column_offset,
    output ready
  );
endinterface

FILE: hdl/nacg_res_if.sv
interface nacg_res_if;
  logic                        valid;
  logic                        ready;
  logic [nacg_pkg::ByteW-1:0]  address_byte;
  logic                        last_cycle;
  logic                        range_error;

  modport source (
    output valid, address_byte, last_cycle, range_error,
    input  ready
  );
  modport sink (
    input  valid, address_byte, last_cycle, range_error,
    output ready
  );
endinterface

FILE: hdl/nand_address_cycle_generator_unit.sv
// Channel   Dir  Transfer
// req       in   one access request: mode, unit, plane, block, page, column offset
// res       out  one address byte with last_cycle and range_error flags
// wr_*      in   register write: wr_en, wr_index, wr_data
//
// A request passes an input register, a check and row multiply into the job
// register, and then one address byte per cycle, while res is not stalled, into the output register.
// A page request sends column_cycles + row_cycles address bytes, an erase
// row_cycles alone and an error one; the next request is taken while one is
// serialised.
// With the serialiser idle, a request passes the input register and the job
// register before its first byte is registered onto res.
// Reset is synchronous and clears all valid flags and sets register defaults.
// A stall on res holds the output byte and backs up into req.ready.
module nand_address_cycle_generator_unit #(
  parameter int MAX_ADDRESS_CYCLES = nacg_pkg::MaxAddressCycles
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [nacg_pkg::CfgIndexW-1:0]   wr_index,
  input  logic [nacg_pkg::CfgDataW-1:0]    wr_data,
  nacg_req_if.sink                         req,
  nacg_res_if.source                       res
);

  nacg_pkg::cfg_t  cfg;
  nacg_pkg::req_t  req_q;
  nacg_pkg::job_t  job_in;
  logic            req_valid;
  logic            job_ready;
  logic            job_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_cycles      <= 3'd2;
      cfg.row_cycles         <= 3'd3;
      cfg.block_pages        <= 11'd64;
      cfg.block_count        <= 17'd1024;
      cfg.page_total_size    <= 17'd2112;
      cfg.plane_count        <= 4'd1;
      cfg.logical_unit_count <= 4'd1;
    end else if (wr_en) begin
      case (nacg_pkg::cfg_index_t'(wr_index))
        nacg_pkg::CfgColumnCycles:   cfg.column_cycles      <= wr_data[2:0];
        nacg_pkg::CfgRowCycles:      cfg.row_cycles         <= wr_data[2:0];
        nacg_pkg::CfgBlockPages:     cfg.block_pages        <= wr_data[10:0];
        nacg_pkg::CfgBlockCount:     cfg.block_count        <= wr_data[16:0];
        nacg_pkg::CfgPageTotalSize:  cfg.page_total_size    <= wr_data[16:0];
        nacg_pkg::CfgPlaneCount:     cfg.plane_count        <= wr_data[3:0];
        nacg_pkg::CfgLogicalUnitCnt: cfg.logical_unit_count <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register; it frees whenever the serialiser takes its request.
  assign job_load  = req_valid && job_ready;
  assign req.ready = !req_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      req_valid <= 1'b1;
    end else if (job_load) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q.mode          <= req.mode;
      req_q.logical_unit  <= req.logical_unit;
      req_q.plane_index   <= req.plane_index;
      req_q.block_index   <= req.block_index;
      req_q.page_index    <= req.page_index;
      req_q.column_offset <= req.column_offset;
    end
  end

  // Limit check and row address.
  nacg_check #(
    .MAX_ADDRESS_CYCLES(MAX_ADDRESS_CYCLES)
  ) u_check (
    .req (req_q),
    .cfg (cfg),
    .job (job_in)
  );

  // Byte serialiser with output register.
  nacg_serializer #(
    .MAX_ADDRESS_CYCLES(MAX_ADDRESS_CYCLES)
  ) u_serializer (
    .clk       (clk),
    .rst       (rst),
    .job_load  (job_load),
    .job_in    (job_in),
    .job_ready (job_ready),
    .res       (res)
  );

endmodule

FILE: hdl/nacg_check.sv
module nacg_check #(
  parameter int MAX_ADDRESS_CYCLES = nacg_pkg::MaxAddressCycles
) (
  input  nacg_pkg::req_t req,
  input  nacg_pkg::cfg_t cfg,
  output nacg_pkg::job_t job
);

  localparam logic [nacg_pkg::TotalW:0] MaxCyc = (nacg_pkg::TotalW + 1)'(MAX_ADDRESS_CYCLES);

  logic                          erase;
  logic [nacg_pkg::CycW-1:0]     ncol;
  logic [nacg_pkg::TotalW-1:0]   total;
  logic                          ok;
  logic [nacg_pkg::RowW-1:0]     prod;
  logic [nacg_pkg::RowW-1:0]     row;

  // Cycle counts for this request; erase sends no column bytes.
  assign erase = req.mode;
  assign ncol  = erase ? '0 : cfg.column_cycles;
  assign total = nacg_pkg::TotalW'(ncol) + nacg_pkg::TotalW'(cfg.row_cycles);

  // Limit checks on the indices and on the cycle counts.
  always_comb begin
    ok = 1'b1;
    if ({1'b0, req.block_index} >= cfg.block_count ||
        {1'b0, req.plane_index} >= cfg.plane_count ||
        {1'b0, req.logical_unit} >= cfg.logical_unit_count) begin
      ok = 1'b0;
    end
    if (!erase && ({1'b0, req.page_index} >= cfg.block_pages ||
                   {1'b0, req.column_offset} >= cfg.page_total_size)) begin
      ok = 1'b0;
    end
    if (ncol > nacg_pkg::CycleLimit || cfg.row_cycles == '0 ||
        cfg.row_cycles > nacg_pkg::CycleLimit) begin
      ok = 1'b0;
    end
    if ({1'b0, total} > MaxCyc) begin
      ok = 1'b0;
    end
  end

  // Row address: block times pages per block, plus the page in page mode.
  assign prod = nacg_pkg::RowW'(req.block_index) * nacg_pkg::RowW'(cfg.block_pages);
  assign row  = prod + (erase ? '0 : nacg_pkg::RowW'(req.page_index));

  // An error sends one result and nothing else.
  always_comb begin
    job.err   = !ok;
    job.ncol  = ncol;
    job.total = ok ? total : nacg_pkg::TotalW'(1);
    job.col   = req.column_offset;
    job.row   = row;
  end

endmodule

FILE: hdl/nacg_serializer.sv
`include "nand_address_cycle_generator_unit_macros.svh"

module nacg_serializer #(
  parameter int MAX_ADDRESS_CYCLES = nacg_pkg::MaxAddressCycles
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_load,
  input  nacg_pkg::job_t   job_in,
  output logic             job_ready,
  nacg_res_if.source       res
);

  localparam int CntW = $clog2(MAX_ADDRESS_CYCLES + 1);

  nacg_pkg::job_t                job;
  logic                          job_valid;
  logic [CntW-1:0]               idx;
  logic                          out_valid;

  logic                          issue;
  logic                          issue_last;
  logic [nacg_pkg::TotalW-1:0]   idx_w;
  logic [nacg_pkg::TotalW-1:0]   rel;
  logic                          in_col;
  logic [31:0]                   col_word;
  logic [31:0]                   row_word;
  logic [nacg_pkg::ByteW-1:0]    byte_next;
  logic                          last_next;

  // A byte leaves the job register whenever the output register is free.
  assign issue      = job_valid && (!out_valid || res.ready);
  assign idx_w      = nacg_pkg::TotalW'(idx);
  assign last_next  = job.err || (idx_w + nacg_pkg::TotalW'(1) == job.total);
  assign issue_last = issue && last_next;
  assign job_ready  = !job_valid || issue_last;

  // Pick the current byte: column bytes first, then row bytes, low byte first.
  assign in_col   = idx_w < nacg_pkg::TotalW'(job.ncol);
  assign rel      = idx_w - nacg_pkg::TotalW'(job.ncol);
  assign col_word = 32'(job.col);
  assign row_word = 32'(job.row);

  always_comb begin
    if (job.err) begin
      byte_next = '0;
    end else if (in_col) begin
      byte_next = col_word[8*idx[1:0] +: 8];
    end else begin
      byte_next = row_word[8*rel[1:0] +: 8];
    end
  end

  // Job register and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_load) begin
        job_valid <= 1'b1;
        idx       <= '0;
      end else if (issue_last) begin
        job_valid <= 1'b0;
      end else if (issue) begin
        idx <= idx + CntW'(1);
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end
    if (issue) begin
      res.address_byte <= byte_next;
      res.last_cycle   <= last_next;
      res.range_error  <= job.err;
    end
  end

  assign res.valid = out_valid;

  `NACG_ASSERT_IMP(a_load_free, clk, rst, job_load, !job_valid || issue_last)
  `NACG_ASSERT_IMP(a_err_single, clk, rst, issue && job.err, issue_last)
  `NACG_ASSERT_IMP(a_idx_bound, clk, rst, job_valid, idx_w < job.total)
  `NACG_ASSERT_NXT(a_job_done, clk, rst, issue_last && !job_load, !job_valid)

endmodule
